>>> rtl/tlcg_pkg.sv
package tlcg_pkg;

    // Datapath sizing
    localparam int STATE_BITS  = 20;
    localparam int MAX_DRAWS   = 48;
    localparam int FREE_BITS   = 16;
    localparam int NIBBLE_BITS = 4;
    localparam int SHIFT_W     = 5;
    localparam int COUNT_W     = 6;
    localparam int MAX_SHIFT   = STATE_BITS - NIBBLE_BITS;

    // Pipeline shape: three front stages, then one stage per checked draw
    localparam int FIRST_STEP  = 2;
    localparam int NUM_STEPS   = MAX_DRAWS - FIRST_STEP;
    localparam int FRONT_DEPTH = 3;
    localparam int PIPE_DEPTH  = FRONT_DEPTH + NUM_STEPS;

    // Register map
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_MULT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OBS_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OBS_MID   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OBS_HIGH  = 3'd5;

    typedef logic [STATE_BITS-1:0]  state_t;
    typedef logic [NIBBLE_BITS-1:0] nibble_t;

    // Settled configuration shared by all stages
    typedef struct packed {
        state_t               mult;
        logic [SHIFT_W-1:0]   shift;
        state_t               mask;
        state_t               low_mask;
        state_t               nib_mask;
        logic [COUNT_W-1:0]   count;
    } cfg_t;

    // Contents of one pipeline stage
    typedef struct packed {
        logic   valid;
        logic   ok;
        state_t x0;
        state_t inc;
        state_t t;
    } stage_t;

    // Mask with the low 'width' bits set
    function automatic state_t low_bits_mask(input logic [SHIFT_W:0] width);
        state_t m;
        m = '0;
        for (int i = 0; i < STATE_BITS; i++)
        begin
            m[i] = (width > (SHIFT_W+1)'(i));
        end
        return m;
    endfunction

endpackage

>>> rtl/tlcg_front.sv
module tlcg_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [tlcg_pkg::FREE_BITS-1:0] first_free_bits,
    input  logic [tlcg_pkg::FREE_BITS-1:0] second_free_bits,
    input  tlcg_pkg::nibble_t           obs_first,
    input  tlcg_pkg::nibble_t           obs_second,
    input  tlcg_pkg::cfg_t              cfg,
    output tlcg_pkg::stage_t            out_stage
);
    import tlcg_pkg::*;

    logic   s1_valid_reg;
    state_t s1_x0_reg, s1_x1_reg;
    state_t s1_x0_next, s1_x1_next;

    logic   s2_valid_reg;
    state_t s2_x0_reg, s2_x1_reg, s2_prod_reg;
    logic [2*STATE_BITS-1:0] s2_prod_full;

    stage_t s3_reg, s3_next;

    // Stage 1: insert the observed nibbles into the free bits
    assign s1_x0_next = ((state_t'(obs_first) << cfg.shift)
                        | (state_t'(first_free_bits) & cfg.low_mask)) & cfg.mask;
    assign s1_x1_next = ((state_t'(obs_second) << cfg.shift)
                        | (state_t'(second_free_bits) & cfg.low_mask)) & cfg.mask;

    // Stage 2: A * x0
    assign s2_prod_full = cfg.mult * s1_x0_reg;

    // Stage 3: increment = x1 - A*x0, walk starts from x1
    always_comb
    begin
        s3_next.valid = s2_valid_reg;
        s3_next.ok    = 1'b1;
        s3_next.x0    = s2_x0_reg;
        s3_next.inc   = (s2_x1_reg - s2_prod_reg) & cfg.mask;
        s3_next.t     = s2_x1_reg;
    end

    // Valid bits and the stage 3 register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_reg       <= s3_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        s1_x0_reg   <= s1_x0_next;
        s1_x1_reg   <= s1_x1_next;
        s2_x0_reg   <= s1_x0_reg;
        s2_x1_reg   <= s1_x1_reg;
        s2_prod_reg <= s2_prod_full[STATE_BITS-1:0] & cfg.mask;
    end

    assign out_stage = s3_reg;

endmodule

>>> rtl/tlcg_step.sv
module tlcg_step (
    input  logic              clk,
    input  logic              rst_n,
    input  tlcg_pkg::stage_t  in_stage,
    input  tlcg_pkg::cfg_t    cfg,
    input  logic              check_en,
    input  tlcg_pkg::nibble_t obs_nib,
    output tlcg_pkg::stage_t  out_stage
);
    import tlcg_pkg::*;

    logic [2*STATE_BITS-1:0] prod;
    state_t                  expected;
    logic                    hit;
    stage_t                  stage_reg, stage_next;

    // One generator step and its nibble compare
    assign prod     = cfg.mult * in_stage.t;
    assign expected = state_t'(obs_nib) << cfg.shift;

    always_comb
    begin
        stage_next.valid = in_stage.valid;
        stage_next.x0    = in_stage.x0;
        stage_next.inc   = in_stage.inc;
        stage_next.t     = (prod[STATE_BITS-1:0] + in_stage.inc) & cfg.mask;
        hit              = ((stage_next.t ^ expected) & cfg.nib_mask) == '0;
        stage_next.ok    = in_stage.ok & (hit | ~check_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_stage = stage_reg;

endmodule

>>> rtl/truncated_lcg_candidate_check_top.sv
// The pipeline has three front stages, then one stage per draw 2 to 47, each a multiply-add.
// Throughput: one candidate per cycle; busy stays low, the pipeline never stalls.
// Each result is shown for one cycle; the receiver cannot hold it off.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the register
// defaults: multiplier 1, shift 16, draw count 48, observations zero.
module truncated_lcg_candidate_check_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // command side
    input  logic                                start,
    output logic                                busy,
    input  logic [tlcg_pkg::FREE_BITS-1:0]      first_free_bits,
    input  logic [tlcg_pkg::FREE_BITS-1:0]      second_free_bits,
    // result side
    output logic                                done,
    output logic                                match,
    output logic [tlcg_pkg::STATE_BITS-1:0]     start_state,
    output logic [tlcg_pkg::STATE_BITS-1:0]     increment,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tlcg_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [tlcg_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [tlcg_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import tlcg_pkg::*;

    logic [19:0]               jump_mult_reg;
    logic [SHIFT_W-1:0]        shift_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [CFG_DATA_W-1:0]     obs_low_reg, obs_mid_reg, obs_high_reg;
    logic                      cfg_write;
    logic [CFG_IDX_W-1:0]      reg_idx;
    logic [SHIFT_W-1:0]        shift_eff;
    logic [3*CFG_DATA_W-1:0]   obs_all;
    cfg_t                      cfg;
    stage_t                    chain [0:NUM_STEPS];

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign reg_idx   = paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W];
    assign cfg_write = psel & penable & pwrite & pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jump_mult_reg <= 20'd1;
            shift_reg     <= SHIFT_W'(16);
            count_reg     <= COUNT_W'(48);
            obs_low_reg   <= '0;
            obs_mid_reg   <= '0;
            obs_high_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_JUMP_MULT: jump_mult_reg <= pwdata[19:0];
                REG_SHIFT:     shift_reg     <= pwdata[SHIFT_W-1:0];
                REG_COUNT:     count_reg     <= pwdata[COUNT_W-1:0];
                REG_OBS_LOW:   obs_low_reg   <= pwdata;
                REG_OBS_MID:   obs_mid_reg   <= pwdata;
                REG_OBS_HIGH:  obs_high_reg  <= pwdata;
                default:       ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_idx)
            REG_JUMP_MULT: prdata = CFG_DATA_W'(jump_mult_reg);
            REG_SHIFT:     prdata = CFG_DATA_W'(shift_reg);
            REG_COUNT:     prdata = CFG_DATA_W'(count_reg);
            REG_OBS_LOW:   prdata = obs_low_reg;
            REG_OBS_MID:   prdata = obs_mid_reg;
            REG_OBS_HIGH:  prdata = obs_high_reg;
            default:       prdata = '0;
        endcase
    end

    // Settled configuration: saturated shift and count, masks
    assign shift_eff = (shift_reg > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : shift_reg;

    always_comb
    begin
        cfg.shift    = shift_eff;
        cfg.mask     = low_bits_mask({1'b0, shift_eff} + (SHIFT_W+1)'(NIBBLE_BITS));
        cfg.low_mask = low_bits_mask({1'b0, shift_eff});
        cfg.nib_mask = cfg.mask & ~cfg.low_mask;
        cfg.mult     = STATE_BITS'(jump_mult_reg) & cfg.mask;
        cfg.count    = (count_reg > COUNT_W'(MAX_DRAWS)) ? COUNT_W'(MAX_DRAWS) : count_reg;
    end

    assign obs_all = {obs_high_reg, obs_mid_reg, obs_low_reg};

    // Front: assemble x0/x1, derive the increment
    tlcg_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (start & ~busy),
        .first_free_bits  (first_free_bits),
        .second_free_bits (second_free_bits),
        .obs_first        (obs_all[0 +: NIBBLE_BITS]),
        .obs_second       (obs_all[NIBBLE_BITS +: NIBBLE_BITS]),
        .cfg              (cfg),
        .out_stage        (chain[0])
    );

    // One stage per checked draw
    for (genvar g = 0; g < NUM_STEPS; g++)
    begin : g_step
        localparam int DRAW = g + FIRST_STEP;
        tlcg_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_stage  (chain[g]),
            .cfg       (cfg),
            .check_en  (COUNT_W'(DRAW) < cfg.count),
            .obs_nib   (obs_all[NIBBLE_BITS*DRAW +: NIBBLE_BITS]),
            .out_stage (chain[g+1])
        );
    end

    // Result strobe straight from the last stage
    assign done        = chain[NUM_STEPS].valid;
    assign match       = chain[NUM_STEPS].ok;
    assign start_state = chain[NUM_STEPS].x0;
    assign increment   = chain[NUM_STEPS].inc;

    // Every result traces back to an earlier accepted command
    a_done_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_DEPTH))
        else $error("result without matching command");

    // Reported state and increment stay within the state width
    a_width_mask: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (((start_state | increment) & ~cfg.mask) == '0))
        else $error("result bits above state width");

    // With fewer than three draws nothing is checked
    a_short_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (cfg.count < COUNT_W'(FIRST_STEP + 1))) |-> match)
        else $error("mismatch reported with no draws checked");

endmodule
